>>> hw/rtl/pdrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdrt_pkg
// Types, codes and widths shared by the path delay response time block.
// ----------------------------------------------------------------------------
package pdrt_pkg;

    localparam int FLOW_ID_W   = 16;
    localparam int BW_W        = 36;
    localparam int PERIOD_W    = 32;
    localparam int PRIO_W      = 8;
    localparam int DELAY_W     = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 36;

    // bit-serial multiplier: 48 x 32 -> 80
    localparam int MCAND_W     = 48;
    localparam int MPLIER_W    = 32;
    localparam int PROD_W      = MCAND_W + MPLIER_W;
    localparam int MUL_CNT_W   = $clog2(MPLIER_W + 1);

    // restoring divider: 68 / 36 -> 68
    localparam int DIVIDEND_W  = BW_W + PERIOD_W;
    localparam int DIVISOR_W   = BW_W;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
    localparam int CEIL_W      = PERIOD_W + 1;

    localparam logic [DELAY_W-1:0] MAX_DELAY = {DELAY_W{1'b1}};

    localparam logic [1:0] KIND_LINK   = 2'd0;
    localparam logic [1:0] KIND_NODE   = 2'd1;
    localparam logic [1:0] KIND_INTERF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_FLOW_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_BANDWIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_PRIORITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INCL_NODE     = 3'd5;

    typedef struct packed {
        logic [1:0]           kind;
        logic [BW_W-1:0]      capacity;
        logic [FLOW_ID_W-1:0] other_flow_id;
        logic [BW_W-1:0]      other_bandwidth;
        logic [PERIOD_W-1:0]  other_period;
        logic [PRIO_W-1:0]    other_priority;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] total_delay;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        logic                start;
        logic [MCAND_W-1:0]  multiplicand;
        logic [MPLIER_W-1:0] multiplier;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [DIV_CNT_W-1:0]  steps;
    } div_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_WAIT,
        S_DIV_WAIT,
        S_CEIL_WAIT,
        S_PROD_WAIT,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/pdrt_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdrt_mul
// Shift-add multiplier, one multiplier bit per cycle, 48 x 32 -> 80 bits.
// ----------------------------------------------------------------------------
module pdrt_mul
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pdrt_pkg::mul_req_t               req,
    output logic                                  done,
    output logic [pdrt_pkg::PROD_W-1:0]           product
);
    import pdrt_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [MCAND_W-1:0]   mcand_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MCAND_W:0]     part_sum;

    assign part_sum = {1'b0, prod_reg[PROD_W-1:MPLIER_W]}
                    + (prod_reg[0] ? {1'b0, mcand_reg} : {(MCAND_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MPLIER_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg  <= {{MCAND_W{1'b0}}, req.multiplier};
            mcand_reg <= req.multiplicand;
        end
        else if (busy_reg)
        begin
            prod_reg <= {part_sum, prod_reg[MPLIER_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pdrt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdrt_div
// Restoring divider, one quotient bit per cycle, 68 / 36 bits.
// ----------------------------------------------------------------------------
module pdrt_div
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pdrt_pkg::div_req_t                req,
    output logic                                   done,
    output logic [pdrt_pkg::DIVIDEND_W-1:0]        quotient
);
    import pdrt_pkg::*;

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dsor_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsor_reg};
    assign fits      = ~diff[DIVISOR_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dsor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/path_delay_response_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// path_delay_response_time
// A link item, or a node item with node inclusion set, runs a bit-serial
// multiply then a restoring divide; a counted interfering flow adds a ceiling
// divide and a second multiply; other items go from dispatch to finish.
// Items are taken one at a time, item_stall high until idle again; the result
// register frees the input side, but a last item waits while output stalls.
// Reset: registers to defaults, path cleared, node capacity one.
// ----------------------------------------------------------------------------
module path_delay_response_time
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [pdrt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pdrt_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire pdrt_pkg::item_t                       item,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output pdrt_pkg::result_t                          result
);
    import pdrt_pkg::*;

    logic [FLOW_ID_W-1:0] own_flow_id_reg;
    logic [BW_W-1:0]      own_bandwidth_reg;
    logic [PERIOD_W-1:0]  own_period_reg;
    logic [PRIO_W-1:0]    own_priority_reg;
    logic [PERIOD_W-1:0]  prop_delay_reg;
    logic                 incl_node_reg;

    state_t               state_reg, state_next;
    item_t                item_reg;
    logic [BW_W-1:0]      node_cap_reg;
    logic [BW_W-1:0]      divisor_reg;
    logic [DELAY_W-1:0]   delay_sum_reg;
    logic                 saturated_reg;
    logic [DELAY_W-1:0]   q_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    mul_req_t             mul_req;
    div_req_t             div_req;
    logic                 mul_done;
    logic                 div_done;
    logic [PROD_W-1:0]    product;
    logic [DIVIDEND_W-1:0] quotient;

    logic [BW_W-1:0]      cap_fix;
    logic [PERIOD_W-1:0]  oper_fix;
    logic [CEIL_W-1:0]    ceil_sum;
    logic                 counts;
    logic [DELAY_W-1:0]   quo_sat;
    logic                 quo_ovf;
    logic [DELAY_W-1:0]   prod_sat;
    logic                 prod_ovf;
    logic [DELAY_W:0]     add_wide;

    logic                 accept;
    logic                 add_en;
    logic [DELAY_W-1:0]   add_val;
    logic                 sat_set;
    logic                 node_load;
    logic                 div_load;
    logic                 q_load;
    logic                 out_load;

    pdrt_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (product)
    );

    pdrt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    assign accept   = item_valid && !item_stall;
    assign cap_fix  = (item_reg.capacity == '0) ? BW_W'(1) : item_reg.capacity;
    assign oper_fix = (item_reg.other_period == '0) ? PERIOD_W'(1) : item_reg.other_period;
    assign ceil_sum = {1'b0, own_period_reg} + {1'b0, oper_fix} - CEIL_W'(1);
    assign counts   = incl_node_reg && (item_reg.other_flow_id != own_flow_id_reg)
                      && (own_priority_reg >= item_reg.other_priority);
    assign quo_ovf  = |quotient[DIVIDEND_W-1:DELAY_W];
    assign quo_sat  = quo_ovf ? MAX_DELAY : quotient[DELAY_W-1:0];
    assign prod_ovf = |product[PROD_W-1:DELAY_W];
    assign prod_sat = prod_ovf ? MAX_DELAY : product[DELAY_W-1:0];
    assign add_wide = {1'b0, delay_sum_reg} + {1'b0, add_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_req    = '0;
        div_req    = '0;
        add_en     = 1'b0;
        add_val    = '0;
        sat_set    = 1'b0;
        node_load  = 1'b0;
        div_load   = 1'b0;
        q_load     = 1'b0;
        out_load   = 1'b0;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (item_reg.kind)
                    KIND_LINK:
                    begin
                        add_en               = 1'b1;
                        add_val              = {{(DELAY_W-PERIOD_W){1'b0}}, prop_delay_reg};
                        div_load             = 1'b1;
                        mul_req.start        = 1'b1;
                        mul_req.multiplicand = {{(MCAND_W-BW_W){1'b0}}, own_bandwidth_reg};
                        mul_req.multiplier   = own_period_reg;
                        state_next           = S_MUL_WAIT;
                    end
                    KIND_NODE:
                    begin
                        node_load = 1'b1;
                        div_load  = 1'b1;
                        if (incl_node_reg)
                        begin
                            mul_req.start        = 1'b1;
                            mul_req.multiplicand = {{(MCAND_W-BW_W){1'b0}}, own_bandwidth_reg};
                            mul_req.multiplier   = own_period_reg;
                            state_next           = S_MUL_WAIT;
                        end
                    end
                    KIND_INTERF:
                    begin
                        if (counts)
                        begin
                            mul_req.start        = 1'b1;
                            mul_req.multiplicand = {{(MCAND_W-BW_W){1'b0}},
                                                    item_reg.other_bandwidth};
                            mul_req.multiplier   = item_reg.other_period;
                            state_next           = S_MUL_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = product[DIVIDEND_W-1:0];
                    div_req.divisor  = (item_reg.kind == KIND_INTERF) ? node_cap_reg
                                                                      : divisor_reg;
                    div_req.steps    = DIV_CNT_W'(DIVIDEND_W);
                    state_next       = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    sat_set = quo_ovf;
                    if (item_reg.kind == KIND_INTERF)
                    begin
                        q_load           = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = {ceil_sum, {(DIVIDEND_W-CEIL_W){1'b0}}};
                        div_req.divisor  = {{(DIVISOR_W-PERIOD_W){1'b0}}, oper_fix};
                        div_req.steps    = DIV_CNT_W'(CEIL_W);
                        state_next       = S_CEIL_WAIT;
                    end
                    else
                    begin
                        add_en     = 1'b1;
                        add_val    = quo_sat;
                        state_next = S_FINISH;
                    end
                end
            end
            S_CEIL_WAIT:
            begin
                if (div_done)
                begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = q_reg;
                    mul_req.multiplier   = quotient[MPLIER_W-1:0];
                    state_next           = S_PROD_WAIT;
                end
            end
            S_PROD_WAIT:
            begin
                if (mul_done)
                begin
                    sat_set    = prod_ovf;
                    add_en     = 1'b1;
                    add_val    = prod_sat;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!item_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration and path state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_flow_id_reg   <= '0;
            own_bandwidth_reg <= '0;
            own_period_reg    <= PERIOD_W'(1);
            own_priority_reg  <= '0;
            prop_delay_reg    <= '0;
            incl_node_reg     <= 1'b1;
            node_cap_reg      <= BW_W'(1);
            delay_sum_reg     <= '0;
            saturated_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OWN_FLOW_ID:   own_flow_id_reg   <= cfg_data[FLOW_ID_W-1:0];
                    REG_OWN_BANDWIDTH: own_bandwidth_reg <= cfg_data[BW_W-1:0];
                    REG_OWN_PERIOD:    own_period_reg    <= cfg_data[PERIOD_W-1:0];
                    REG_OWN_PRIORITY:  own_priority_reg  <= cfg_data[PRIO_W-1:0];
                    REG_PROP_DELAY:    prop_delay_reg    <= cfg_data[PERIOD_W-1:0];
                    REG_INCL_NODE:     incl_node_reg     <= cfg_data[0];
                    default:           ;
                endcase
            end

            if (node_load)
            begin
                node_cap_reg <= cap_fix;
            end

            if (add_en)
            begin
                if (add_wide[DELAY_W])
                begin
                    delay_sum_reg <= MAX_DELAY;
                    saturated_reg <= 1'b1;
                end
                else
                begin
                    delay_sum_reg <= add_wide[DELAY_W-1:0];
                end
            end
            if (sat_set)
            begin
                saturated_reg <= 1'b1;
            end

            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
                node_cap_reg     <= BW_W'(1);
                delay_sum_reg    <= '0;
                saturated_reg    <= 1'b0;
            end
        end
    end

    // item payload and operand holding
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (div_load)
        begin
            divisor_reg <= cap_fix;
        end
        if (q_load)
        begin
            q_reg <= quo_sat;
        end
        if (out_load)
        begin
            result_reg.total_delay <= delay_sum_reg;
            result_reg.overflowed  <= saturated_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
